FILE: rtl/spi_pkg.sv
// Shared types and constants of the segment pair intersection block.
`default_nettype none

package spi_pkg;

  typedef enum logic [1:0] {
    REL_CROSS    = 2'd0,
    REL_PARALLEL = 2'd1,
    REL_SAME     = 2'd2
  } relation_e;

  // Per-item control that travels down the pipeline next to the data.
  typedef struct packed {
    relation_e relation;
    logic      hit;
    logic      neg_x;
    logic      neg_y;
    logic      ovf_x;
    logic      ovf_y;
  } meta_t;

  // Quotient bits kept by the divider; anything at or above 2^33 saturates.
  localparam int QBITS      = 33;
  localparam int POINT_W    = 32;
  localparam int OUT_DATA_W = 72;

  localparam logic [POINT_W-1:0] PT_MAX = 32'h7FFF_FFFF;
  localparam logic [POINT_W-1:0] PT_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

FILE: rtl/spi_front.sv
// Front stages: edge vectors, cross products, classification and numerator products.
`default_nettype none

module spi_front #(
  parameter int W = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              valid_i,
  input  wire  [8*W-1:0]                   tdata_i,
  output logic                             valid_o,
  output spi_pkg::relation_e               relation_o,
  output logic                             hit_o,
  output logic [2*W+1:0]                   den_o,
  output logic signed [3*W+3:0]            px1_o,
  output logic signed [3*W+3:0]            px2_o,
  output logic signed [3*W+3:0]            py1_o,
  output logic signed [3*W+3:0]            py2_o
);

  import spi_pkg::*;

  localparam int D   = W + 1;
  localparam int CW  = 2 * W + 3;
  localparam int PWD = 3 * W + 4;
  localparam int DW  = 2 * W + 2;

  logic signed [W-1:0] a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y;

  assign a1x = tdata_i[0*W +: W];
  assign a1y = tdata_i[1*W +: W];
  assign b1x = tdata_i[2*W +: W];
  assign b1y = tdata_i[3*W +: W];
  assign a2x = tdata_i[4*W +: W];
  assign a2y = tdata_i[5*W +: W];
  assign b2x = tdata_i[6*W +: W];
  assign b2y = tdata_i[7*W +: W];

  // Stage 1: differences.
  logic signed [D-1:0] d1x_d, d1y_d, d2x_d, d2y_d, wx_d, wy_d;
  logic signed [D-1:0] d1x_q, d1y_q, d2x_q, d2y_q, wx_q, wy_q;
  logic signed [W-1:0] a1x_q, a1y_q;
  logic                zero1_q;
  logic                v1_q;

  always_comb begin
    d1x_d = D'(b1x) - D'(a1x);
    d1y_d = D'(b1y) - D'(a1y);
    d2x_d = D'(b2x) - D'(a2x);
    d2y_d = D'(b2y) - D'(a2y);
    wx_d  = D'(a2x) - D'(a1x);
    wy_d  = D'(a2y) - D'(a1y);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1x_q   <= d1x_d;
      d1y_q   <= d1y_d;
      d2x_q   <= d2x_d;
      d2y_q   <= d2y_d;
      wx_q    <= wx_d;
      wy_q    <= wy_d;
      a1x_q   <= a1x;
      a1y_q   <= a1y;
      zero1_q <= (d1x_d == '0) && (d1y_d == '0);
    end
  end

  // Stage 2: the three cross products.
  logic signed [2*D-1:0] pd_a, pd_b, pt_a, pt_b, pu_a, pu_b;
  logic signed [CW-1:0]  den_d, tn_d, un_d;
  logic signed [CW-1:0]  den2_q, tn2_q, un2_q;
  logic signed [W-1:0]   a1x2_q, a1y2_q;
  logic signed [D-1:0]   d1x2_q, d1y2_q;
  logic                  zero1_2_q;
  logic                  v2_q;

  always_comb begin
    pd_a  = d1x_q * d2y_q;
    pd_b  = d1y_q * d2x_q;
    pt_a  = wx_q * d2y_q;
    pt_b  = wy_q * d2x_q;
    pu_a  = wx_q * d1y_q;
    pu_b  = wy_q * d1x_q;
    den_d = CW'(pd_a) - CW'(pd_b);
    tn_d  = CW'(pt_a) - CW'(pt_b);
    un_d  = CW'(pu_a) - CW'(pu_b);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den2_q    <= den_d;
      tn2_q     <= tn_d;
      un2_q     <= un_d;
      a1x2_q    <= a1x_q;
      a1y2_q    <= a1y_q;
      d1x2_q    <= d1x_q;
      d1y2_q    <= d1y_q;
      zero1_2_q <= zero1_q;
    end
  end

  // Stage 3: sign normalization and classification.
  logic                 den_neg;
  logic signed [CW-1:0] den_n, tn_n, un_n;
  relation_e            rel_d;
  logic                 hit_d;
  logic signed [CW-1:0] den3_q, tn3_q;
  logic signed [W-1:0]  a1x3_q, a1y3_q;
  logic signed [D-1:0]  d1x3_q, d1y3_q;
  relation_e            rel3_q;
  logic                 hit3_q;
  logic                 v3_q;

  always_comb begin
    den_neg = den2_q[CW-1];
    den_n   = den_neg ? -den2_q : den2_q;
    tn_n    = den_neg ? -tn2_q  : tn2_q;
    un_n    = den_neg ? -un2_q  : un2_q;
    if (zero1_2_q) begin
      // A first segment of zero length counts as the same line.
      rel_d = REL_SAME;
      hit_d = 1'b1;
    end else if (den2_q == '0) begin
      rel_d = (un2_q != '0) ? REL_PARALLEL : REL_SAME;
      hit_d = (un2_q == '0);
    end else begin
      rel_d = REL_CROSS;
      hit_d = !tn_n[CW-1] && (den_n >= tn_n) && !un_n[CW-1] && (den_n >= un_n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den3_q <= den_n;
      tn3_q  <= tn_n;
      a1x3_q <= a1x2_q;
      a1y3_q <= a1y2_q;
      d1x3_q <= d1x2_q;
      d1y3_q <= d1y2_q;
      rel3_q <= rel_d;
      hit3_q <= hit_d;
    end
  end

  // Stage 4: numerator products.
  logic signed [PWD-1:0] px1_d, px2_d, py1_d, py2_d;

  always_comb begin
    px1_d = a1x3_q * den3_q;
    px2_d = d1x3_q * tn3_q;
    py1_d = a1y3_q * den3_q;
    py2_d = d1y3_q * tn3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px1_o      <= px1_d;
      px2_o      <= px2_d;
      py1_o      <= py1_d;
      py2_o      <= py2_d;
      den_o      <= den3_q[DW-1:0];
      relation_o <= rel3_q;
      hit_o      <= hit3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_o <= v3_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spi_div.sv
// Pipelined restoring divider: one quotient bit per stage, two lanes sharing one divisor.
`default_nettype none

module spi_div #(
  parameter int DW = 34
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          valid_i,
  input  spi_pkg::meta_t               meta_i,
  input  wire  [DW-1:0]                den_i,
  input  wire  [DW-1:0]                rx_i,
  input  wire  [spi_pkg::QBITS-1:0]    lx_i,
  input  wire  [DW-1:0]                ry_i,
  input  wire  [spi_pkg::QBITS-1:0]    ly_i,
  output logic                         valid_o,
  output spi_pkg::meta_t               meta_o,
  output logic [spi_pkg::QBITS-1:0]    qx_o,
  output logic [spi_pkg::QBITS-1:0]    qy_o
);

  import spi_pkg::*;

  logic              v_q   [QBITS];
  meta_t             m_q   [QBITS];
  logic [DW-1:0]     den_q [QBITS];
  logic [DW-1:0]     rx_q  [QBITS];
  logic [DW-1:0]     ry_q  [QBITS];
  logic [QBITS-1:0]  lx_q  [QBITS];
  logic [QBITS-1:0]  ly_q  [QBITS];
  logic [QBITS-1:0]  qx_q  [QBITS];
  logic [QBITS-1:0]  qy_q  [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic              v_c;
    meta_t             m_c;
    logic [DW-1:0]     den_c, rx_c, ry_c;
    logic [QBITS-1:0]  lx_c, ly_c, qx_c, qy_c;
    logic [DW:0]       tx, ty;
    logic              gex, gey;

    if (k == 0) begin : g_first
      assign v_c   = valid_i;
      assign m_c   = meta_i;
      assign den_c = den_i;
      assign rx_c  = rx_i;
      assign ry_c  = ry_i;
      assign lx_c  = lx_i;
      assign ly_c  = ly_i;
      assign qx_c  = '0;
      assign qy_c  = '0;
    end else begin : g_next
      assign v_c   = v_q[k-1];
      assign m_c   = m_q[k-1];
      assign den_c = den_q[k-1];
      assign rx_c  = rx_q[k-1];
      assign ry_c  = ry_q[k-1];
      assign lx_c  = lx_q[k-1];
      assign ly_c  = ly_q[k-1];
      assign qx_c  = qx_q[k-1];
      assign qy_c  = qy_q[k-1];
    end

    always_comb begin
      tx  = {rx_c, lx_c[QBITS-1]};
      ty  = {ry_c, ly_c[QBITS-1]};
      gex = (tx >= {1'b0, den_c});
      gey = (ty >= {1'b0, den_c});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]   <= m_c;
        den_q[k] <= den_c;
        rx_q[k]  <= gex ? DW'(tx - {1'b0, den_c}) : DW'(tx);
        ry_q[k]  <= gey ? DW'(ty - {1'b0, den_c}) : DW'(ty);
        lx_q[k]  <= {lx_c[QBITS-2:0], 1'b0};
        ly_q[k]  <= {ly_c[QBITS-2:0], 1'b0};
        qx_q[k]  <= {qx_c[QBITS-2:0], gex};
        qy_q[k]  <= {qy_c[QBITS-2:0], gey};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_c;
      end
    end
  end

  assign valid_o = v_q[QBITS-1];
  assign meta_o  = m_q[QBITS-1];
  assign qx_o    = qx_q[QBITS-1];
  assign qy_o    = qy_q[QBITS-1];

endmodule

`default_nettype wire

FILE: rtl/segment_pair_intersection.sv
// A segment pair passes through 4 front stages, 1 numerator stage, 33 divider stages
// and 1 output register. Throughput: one segment pair per cycle while not stalled;
// the divider retires one quotient bit per stage.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits asynchronously; data registers are not reset.
`default_nettype none

module segment_pair_intersection #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // s1_ax, s1_ay, s1_bx, s1_by, s2_ax, s2_ay, s2_bx, s2_by
  input  wire  [8*COORD_WIDTH-1:0]         s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  // relation[1:0], hit, point_x[31:0], point_y[31:0], clipped, zero pad
  output logic [spi_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  import spi_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = 2 * W + 2;
  localparam int PWD  = 3 * W + 4;
  localparam int NW   = PWD + 1;
  localparam int MW   = NW + FRAC_BITS;
  localparam int XW   = MW + QBITS;
  localparam int CMPW = MW + DW + QBITS;

  logic en;
  logic out_v_q;

  assign en              = m_axis_tready_i || !out_v_q;
  assign s_axis_tready_o = en;

  logic                   f_v;
  relation_e              f_rel;
  logic                   f_hit;
  logic [DW-1:0]          f_den;
  logic signed [PWD-1:0]  f_px1, f_px2, f_py1, f_py2;

  spi_front #(.W(W)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid_i),
    .tdata_i    (s_axis_tdata_i),
    .valid_o    (f_v),
    .relation_o (f_rel),
    .hit_o      (f_hit),
    .den_o      (f_den),
    .px1_o      (f_px1),
    .px2_o      (f_px2),
    .py1_o      (f_py1),
    .py2_o      (f_py2)
  );

  // Numerator stage: sum, magnitude, fraction shift and overflow check.
  logic signed [NW-1:0] nx1, nx2, ny1, ny2, numx, numy;
  logic [NW-1:0]        magx, magy;
  logic [XW-1:0]        extx, exty;
  logic [CMPW-1:0]      den_cmp;
  meta_t                meta_d;

  always_comb begin
    nx1     = f_px1;
    nx2     = f_px2;
    ny1     = f_py1;
    ny2     = f_py2;
    numx    = nx1 + nx2;
    numy    = ny1 + ny2;
    magx    = numx[NW-1] ? NW'(-numx) : NW'(numx);
    magy    = numy[NW-1] ? NW'(-numy) : NW'(numy);
    extx    = XW'(magx) << FRAC_BITS;
    exty    = XW'(magy) << FRAC_BITS;
    den_cmp = CMPW'(f_den) << QBITS;
    meta_d.relation = f_rel;
    meta_d.hit      = f_hit;
    meta_d.neg_x    = numx[NW-1];
    meta_d.neg_y    = numy[NW-1];
    meta_d.ovf_x    = (CMPW'(extx) >= den_cmp);
    meta_d.ovf_y    = (CMPW'(exty) >= den_cmp);
  end

  logic                 n_v_q;
  meta_t                n_meta_q;
  logic [DW-1:0]        n_den_q, n_rx_q, n_ry_q;
  logic [QBITS-1:0]     n_lx_q, n_ly_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_meta_q <= meta_d;
      n_den_q  <= f_den;
      n_rx_q   <= DW'(extx >> QBITS);
      n_ry_q   <= DW'(exty >> QBITS);
      n_lx_q   <= extx[QBITS-1:0];
      n_ly_q   <= exty[QBITS-1:0];
    end
  end

  logic             d_v;
  meta_t            d_meta;
  logic [QBITS-1:0] d_qx, d_qy;

  spi_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n_v_q),
    .meta_i  (n_meta_q),
    .den_i   (n_den_q),
    .rx_i    (n_rx_q),
    .lx_i    (n_lx_q),
    .ry_i    (n_ry_q),
    .ly_i    (n_ly_q),
    .valid_o (d_v),
    .meta_o  (d_meta),
    .qx_o    (d_qx),
    .qy_o    (d_qy)
  );

  // Output stage: sign, saturation and packing.
  logic               satx, saty;
  logic [POINT_W-1:0] ptx, pty;
  logic               clip;
  logic [OUT_DATA_W-1:0] tdata_d, tdata_q;

  always_comb begin
    if (d_meta.neg_x) begin
      satx = d_meta.ovf_x || (d_qx > {1'b0, PT_MIN});
      ptx  = satx ? PT_MIN : POINT_W'(-d_qx[POINT_W-1:0]);
    end else begin
      satx = d_meta.ovf_x || (d_qx > {1'b0, PT_MAX});
      ptx  = satx ? PT_MAX : d_qx[POINT_W-1:0];
    end
    if (d_meta.neg_y) begin
      saty = d_meta.ovf_y || (d_qy > {1'b0, PT_MIN});
      pty  = saty ? PT_MIN : POINT_W'(-d_qy[POINT_W-1:0]);
    end else begin
      saty = d_meta.ovf_y || (d_qy > {1'b0, PT_MAX});
      pty  = saty ? PT_MAX : d_qy[POINT_W-1:0];
    end
    clip = satx || saty;
    if (d_meta.relation != REL_CROSS) begin
      ptx  = '0;
      pty  = '0;
      clip = 1'b0;
    end
    tdata_d = {4'b0, clip, pty, ptx, d_meta.hit, d_meta.relation};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= tdata_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      n_v_q   <= f_v;
      out_v_q <= d_v;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = tdata_q;

endmodule

`default_nettype wire

FILE: rtl/spi_checker.sv
// Port-level checks for the segment pair intersection block, bound to the top level.
`default_nettype none

module spi_checker #(
  parameter int COORD_WIDTH = 16
) (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid_i,
  input wire                             s_axis_tready_o,
  input wire [8*COORD_WIDTH-1:0]         s_axis_tdata_i,
  input wire                             m_axis_tvalid_o,
  input wire                             m_axis_tready_i,
  input wire [spi_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  import spi_pkg::*;

  logic [1:0]         rel;
  logic               hit;
  logic [POINT_W-1:0] px, py;
  logic               clip;

  assign rel  = m_axis_tdata_o[1:0];
  assign hit  = m_axis_tdata_o[2];
  assign px   = m_axis_tdata_o[34:3];
  assign py   = m_axis_tdata_o[66:35];
  assign clip = m_axis_tdata_o[67];

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (rel != REL_CROSS) |-> (px == '0) && (py == '0) && !clip)
    else $error("point reported without a crossing");

  a_same_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (rel == REL_SAME) |-> hit)
    else $error("same line without hit");

  a_clip_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && clip |->
      (px == PT_MAX) || (px == PT_MIN) || (py == PT_MAX) || (py == PT_MIN))
    else $error("clipped flag without a saturated coordinate");

  // Every accepted input transfer carries known coordinates.
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> !$isunknown(s_axis_tdata_i))
    else $error("input transfer with unknown data");

endmodule

bind segment_pair_intersection spi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_spi_checker (.*);

`default_nettype wire

FILE: test/tb_segment_pair_intersection.sv
// Testbench for the segment pair intersection block: directed and random pairs.
`timescale 1ns / 100ps
`default_nettype none

module tb_segment_pair_intersection;
  import spi_pkg::*;

  localparam int CW = 16;
  localparam int FB = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    relation_e       relation;
    logic            hit;
    logic [31:0]     point_x;
    logic [31:0]     point_y;
    logic            clipped;
  } crossing_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  wire                  s_axis_tready_o;
  logic [8*CW-1:0]      s_axis_tdata_i = '0;
  wire                  m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // relation[1:0], hit, point_x[31:0], point_y[31:0], clipped, zero pad
  wire [OUT_DATA_W-1:0] m_axis_tdata_o;

  crossing_t expected_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  timed_out = 1'b0;
  bit  calm = 1'b0;
  bit  hold_off = 1'b0;

  segment_pair_intersection #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Truncating divide of num * 2^FB by a positive den, saturated to 32 bits.
  function automatic logic [31:0] scale_div(logic signed [127:0] num,
                                            logic signed [127:0] den, ref bit clip);
    logic          neg;
    logic [127:0]  mag;
    logic [127:0]  q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << FB) / den;
    if (neg) begin
      if (q > 128'h8000_0000) begin
        clip = 1'b1;
        return PT_MIN;
      end
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) begin
      clip = 1'b1;
      return PT_MAX;
    end
    return q[31:0];
  endfunction

  function automatic crossing_t predict_crossing(logic [8*CW-1:0] pair);
    logic signed [127:0] c[8];
    logic signed [127:0] d1x, d1y, d2x, d2y, wx, wy, den, tn, un;
    crossing_t r;
    bit clip;
    for (int i = 0; i < 8; i++) c[i] = 128'(signed'(pair[i*CW +: CW]));
    d1x = c[2] - c[0];
    d1y = c[3] - c[1];
    d2x = c[6] - c[4];
    d2y = c[7] - c[5];
    wx = c[4] - c[0];
    wy = c[5] - c[1];
    r = '{REL_SAME, 1'b1, '0, '0, 1'b0};
    clip = 1'b0;
    if (d1x == 0 && d1y == 0) return r;
    den = d1x * d2y - d1y * d2x;
    tn = wx * d2y - wy * d2x;
    un = wx * d1y - wy * d1x;
    if (den == 0) begin
      if (un != 0) begin
        r.relation = REL_PARALLEL;
        r.hit = 1'b0;
      end
      return r;
    end
    if (den < 0) begin
      den = -den;
      tn = -tn;
      un = -un;
    end
    r.relation = REL_CROSS;
    r.hit = tn >= 0 && tn <= den && un >= 0 && un <= den;
    r.point_x = scale_div(c[0] * den + d1x * tn, den, clip);
    r.point_y = scale_div(c[1] * den + d1y * tn, den, clip);
    r.clipped = clip;
    return r;
  endfunction

  // Called at a falling edge; tvalid stays high after the transfer so that
  // pairs can follow back to back, and drops only while the sender idles.
  task automatic send_pair(logic [15:0] a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y);
    logic [8*CW-1:0] pair;
    pair = {b2y, b2x, a2y, a2x, b1y, b1x, a1y, a1x};
    while (!calm && $urandom_range(99) < 18) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata_i <= pair;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(predict_crossing(pair));
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 40) - 20);
      default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  task automatic test_directed;
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);
    send_pair(0, 0, 4, 0, 0, 1, 4, 1);
    send_pair(0, 0, 4, 4, 8, 8, 12, 12);
    send_pair(3, 3, 3, 3, 1, 2, 5, 7);
    send_pair(0, 0, 4, 4, 2, 2, 2, 2);
    send_pair(0, 0, 4, 4, 2, 3, 2, 3);
    send_pair(0, 0, 1, 0, 5, 5, 5, 6);
    send_pair(0, 0, 4, 0, 4, 0, 4, 9);
    send_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'h7FFF, 16'h8000);
    send_pair(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
              16'h8000, 16'h7FFF);
    // Nearly parallel long lines push the crossing beyond the input coordinate range.
    send_pair(16'h8000, 0, 16'h7FFF, 1, 16'h8000, 1, 16'h7FFF, 3);
    send_pair(16'h8000, 0, 16'h7FFF, 1, 16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFD);
    send_pair(0, 0, 3, 1, 1, 0, 0, 3);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFF0);
    send_pair(0, 0, 7, 3, 0, 0, 16'hFFF9, 16'hFFFD);
  endtask

  task automatic test_random(int count);
    int mode;
    logic [15:0] v[8];
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(3);
      calm = n >= count / 3 && n < count / 2;
      for (int i = 0; i < 8; i++) v[i] = rnd_coord(mode == 3 ? $urandom_range(2) : mode);
      case ($urandom_range(5))
        0: begin
          v[6] = v[4] + (v[2] - v[0]);
          v[7] = v[5] + (v[3] - v[1]);
        end
        1: begin
          v[4] = v[0] + 16'd2 * (v[2] - v[0]);
          v[5] = v[1] + 16'd2 * (v[3] - v[1]);
          v[6] = v[0] - (v[2] - v[0]);
          v[7] = v[1] - (v[3] - v[1]);
        end
        2: if ($urandom_range(1)) {v[2], v[3]} = {v[0], v[1]};
           else {v[6], v[7]} = {v[4], v[5]};
        default: ;
      endcase
      send_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure;
    hold_off = 1'b1;
    fork
      begin
        repeat (120) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(80);
    join
  endtask

  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= calm || $urandom_range(99) >= 18;
  end

  always @(posedge clk_i) begin
    crossing_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.relation = relation_e'(m_axis_tdata_o[1:0]);
      got.hit = m_axis_tdata_o[2];
      got.point_x = m_axis_tdata_o[34:3];
      got.point_y = m_axis_tdata_o[66:35];
      got.clipped = m_axis_tdata_o[67];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transfer: %h", m_axis_tdata_o);
      end else begin
        want = expected_q.pop_front();
        if (got.relation !== want.relation || got.hit !== want.hit ||
            got.point_x !== want.point_x || got.point_y !== want.point_y ||
            got.clipped !== want.clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected rel %0d hit %b x %h y %h clip %b, ",
                      "got rel %0d hit %b x %h y %h clip %b"},
                     want.relation, want.hit, want.point_x, want.point_y, want.clipped,
                     got.relation, got.hit, got.point_x, got.point_y, got.clipped);
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    timed_out = 1'b1;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed;
    test_backpressure;
    test_random(520);
    s_axis_tvalid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (!timed_out) begin
      if (mismatches == 0 && expected_q.size() == 0) begin
        $display("Test completed successfully");
      end else begin
        $display("Test completed with failures");
      end
      $finish;
    end
  end

endmodule

`default_nettype wire
